// ----- rtl/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes and character constants for the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_W = 32;
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W = 4 * BCD_DIGITS;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS = VALUE_W / BITS_PER_STEP;
    localparam int HEX_DIGITS = VALUE_W / 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_UDEC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SDEC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HEX = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [CHAR_W-1:0] DIGIT_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic               hex;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/i2a_front.sv -----
// ----------------------------------------------------------------------------
// i2a_front
// Input stage: takes one beat, decodes the kind and forms the magnitude,
// then hands the job to the queue.
// ----------------------------------------------------------------------------
module i2a_front
    import i2a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]  s_tuser,
    input  q_stat_t            q_stat,
    output logic               push,
    output job_t               push_job
);

    logic valid_reg;
    job_t job_reg;
    job_t job_next;
    logic neg;

    assign push = valid_reg && !q_stat.full;
    assign s_tready = !valid_reg || !q_stat.full;
    assign push_job = job_reg;

    always_comb
    begin
        neg = (s_tuser == KIND_SDEC) && s_tdata[VALUE_W-1];
        job_next.hex = s_tuser[1];
        job_next.neg = neg;
        job_next.mag = neg ? (~s_tdata + VALUE_W'(1)) : s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ----- rtl/i2a_queue.sv -----
// ----------------------------------------------------------------------------
// i2a_queue
// Short job queue between the input stage and the character engine.
// ----------------------------------------------------------------------------
module i2a_queue
    import i2a_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    pop_job,
    output q_stat_t q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push = push && !q_stat.full;
    assign do_pop = pop && !q_stat.empty;
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/i2a_back.sv -----
// ----------------------------------------------------------------------------
// i2a_back
// Character engine: converts a decimal job to BCD four bits a cycle, strips
// leading zeros and sends one character per beat via an output register.
// ----------------------------------------------------------------------------
module i2a_back
    import i2a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_stat_t           q_stat,
    input  job_t              pop_job,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,
    output logic              m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_LEAD = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t             state_reg;
    logic [BCD_W-1:0]   dat_reg;
    logic [VALUE_W-1:0] bin_reg;
    logic [2:0]         cyc_reg;
    logic [1:0]         pfx_reg;
    logic               neg_reg;
    logic [3:0]         rem_reg;
    logic               m_tvalid_reg;
    logic [CHAR_W-1:0]  m_tdata_reg;
    logic               m_tlast_reg;

    logic [BCD_W-1:0]   dabble_next;
    logic [3:0]         lead;
    logic [5:0]         shamt;
    logic               slot_free;
    logic [CHAR_W-1:0]  char_next;
    logic               last_next;

    assign pop = (state_reg == ST_IDLE) && !q_stat.empty;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

    always_comb
    begin
        dabble_next = dat_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (dabble_next[d*4 +: 4] >= 4'd5)
                begin
                    dabble_next[d*4 +: 4] = dabble_next[d*4 +: 4] + 4'd3;
                end
            end
            dabble_next = {dabble_next[BCD_W-2:0], bin_reg[VALUE_W-1-s]};
        end
    end

    always_comb
    begin
        lead = '0;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (dat_reg[d*4 +: 4] != 4'd0)
            begin
                lead = 4'(d);
            end
        end
        shamt = {4'(BCD_DIGITS - 1) - lead, 2'b00};
    end

    always_comb
    begin
        if (pfx_reg == 2'd2)
        begin
            char_next = CH_ZERO;
        end
        else if (pfx_reg == 2'd1)
        begin
            char_next = CH_X;
        end
        else if (neg_reg)
        begin
            char_next = CH_MINUS;
        end
        else
        begin
            char_next = DIGIT_TABLE[dat_reg[BCD_W-1 -: 4]];
        end
        last_next = (pfx_reg == 2'd0) && !neg_reg && (rem_reg == 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            pfx_reg <= '0;
            neg_reg <= 1'b0;
            rem_reg <= '0;
            cyc_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_EMIT && slot_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        if (pop_job.hex)
                        begin
                            pfx_reg <= 2'd2;
                            neg_reg <= 1'b0;
                            rem_reg <= 4'(HEX_DIGITS);
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            pfx_reg <= 2'd0;
                            neg_reg <= pop_job.neg;
                            cyc_reg <= '0;
                            state_reg <= ST_CONV;
                        end
                    end
                end
                ST_CONV:
                begin
                    cyc_reg <= cyc_reg + 3'd1;
                    if (cyc_reg == 3'(CONV_STEPS - 1))
                    begin
                        state_reg <= ST_LEAD;
                    end
                end
                ST_LEAD:
                begin
                    rem_reg <= lead + 4'd1;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        if (pfx_reg != 2'd0)
                        begin
                            pfx_reg <= pfx_reg - 2'd1;
                        end
                        else if (neg_reg)
                        begin
                            neg_reg <= 1'b0;
                        end
                        else
                        begin
                            rem_reg <= rem_reg - 4'd1;
                        end
                        if (last_next)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && !q_stat.empty)
        begin
            if (pop_job.hex)
            begin
                dat_reg <= {pop_job.mag, {(BCD_W - VALUE_W){1'b0}}};
            end
            else
            begin
                dat_reg <= '0;
                bin_reg <= pop_job.mag;
            end
        end
        else if (state_reg == ST_CONV)
        begin
            dat_reg <= dabble_next;
            bin_reg <= bin_reg << BITS_PER_STEP;
        end
        else if (state_reg == ST_LEAD)
        begin
            dat_reg <= dat_reg << shamt;
        end
        else if (state_reg == ST_EMIT && slot_free)
        begin
            m_tdata_reg <= char_next;
            m_tlast_reg <= last_next;
            if (pfx_reg == 2'd0 && !neg_reg)
            begin
                dat_reg <= dat_reg << 4;
            end
        end
    end

endmodule

// ----- rtl/integer_to_ascii_formatter_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a 32-bit value as unsigned decimal, signed decimal or 0x-prefixed
// hex ASCII, one character per output beat.
// ----------------------------------------------------------------------------
// Each input beat carries the value in tdata and the kind in tuser; the
// characters leave most significant first, with tlast on the final one. A
// hex item takes a start state and then ten character beats. A decimal item
// takes a start state, the binary to BCD converter (four bits per cycle), a
// state to drop leading zeros, and then one beat per character (up to
// eleven). The single output register sets the one character per cycle rate
// while m_tready is held high, and a two-entry job queue lets the input side
// take new values while the character engine is busy.
module integer_to_ascii_formatter_core
    import i2a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,    // value[31:0]
    input  logic [KIND_W-1:0]  s_tuser,    // kind[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,    // character[7:0]
    output logic               m_tlast
);

    q_stat_t q_stat;
    logic    push;
    job_t    push_job;
    logic    pop;
    job_t    pop_job;

    i2a_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    i2a_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    i2a_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/i2a_checker.sv -----
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks on the handshakes and character stream of the formatter.
// ----------------------------------------------------------------------------
module i2a_checker
    import i2a_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [CHAR_W-1:0] m_tdata,
    input logic              m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |->
            ((m_tdata >= CH_ZERO && m_tdata <= CH_NINE) ||
             (m_tdata >= CH_A && m_tdata <= CH_F)))
        else $error("final character is not a digit");

    a_x_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == CH_X) |-> !m_tlast)
        else $error("hex prefix marked as final character");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == CH_MINUS) |-> !m_tlast)
        else $error("minus sign marked as final character");

    a_no_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tready, m_tvalid})
        && (!m_tvalid || !$isunknown({m_tdata, m_tlast})))
        else $error("handshake or output beat is unknown");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (.*);

// ----- tb/tb_integer_to_ascii_formatter_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_core
// Drives 32-bit values with unsigned, signed and hex kinds into the formatter
// and checks every character beat and its tlast flag against text formatted
// independently in the testbench, with random gaps on the input and random
// back-pressure on the output outside the back-to-back random test.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_core;
    import i2a_pkg::*;

    localparam logic [KIND_W-1:0] KIND_HEX_ALIAS = 2'd3;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last;
    } char_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]  s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [CHAR_W-1:0]  m_tdata;
    logic               m_tlast;

    char_beat_t pending_chars[$];
    int         mismatches = 0;
    bit         idling_on = 1'b1;

    integer_to_ascii_formatter_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nibble);
        if (nibble < 4'd10)
        begin
            return CH_ZERO + CHAR_W'(nibble);
        end
        return CH_A + CHAR_W'(nibble - 4'd10);
    endfunction

    function automatic void format_value(input logic [KIND_W-1:0] kind,
                                         input logic [VALUE_W-1:0] value);
        logic [CHAR_W-1:0]  text[$];
        logic [VALUE_W-1:0] magnitude;
        char_beat_t         beat;
        if (kind[1])
        begin
            text.push_back(CH_ZERO);
            text.push_back(CH_X);
            for (int shift = 28; shift >= 0; shift -= 4)
            begin
                text.push_back(hex_char(value[shift +: 4]));
            end
        end
        else
        begin
            magnitude = value;
            if (kind == KIND_SDEC && value[VALUE_W-1])
            begin
                text.push_back(CH_MINUS);
                magnitude = -value;
            end
            if (magnitude == '0)
            begin
                text.push_back(CH_ZERO);
            end
            else
            begin
                int mark;
                mark = text.size();
                while (magnitude != '0)
                begin
                    text.insert(mark, CH_ZERO + CHAR_W'(magnitude % 10));
                    magnitude = magnitude / 10;
                end
            end
        end
        foreach (text[i])
        begin
            beat.character = text[i];
            beat.last = (i == text.size() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    task automatic send_value(input logic [KIND_W-1:0] kind,
                              input logic [VALUE_W-1:0] value);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tuser <= kind;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        format_value(kind, value);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] power;
        power = 1;
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(0, 99999);
            2:
            begin
                repeat ($urandom_range(0, 9)) power = power * 10;
                return power + VALUE_W'($urandom_range(0, 2)) - 1;
            end
            3: return 32'h8000_0000 + VALUE_W'($urandom_range(0, 3)) - 2;
            4: return 32'hFFFF_FFFF - VALUE_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] random_kind();
        case ($urandom_range(0, 6))
            0, 1: return KIND_UDEC;
            2, 3: return KIND_SDEC;
            4, 5: return KIND_HEX;
            default: return KIND_HEX_ALIAS;
        endcase
    endfunction

    task automatic test_directed_cases();
        send_value(KIND_UDEC, 32'd0);
        send_value(KIND_UDEC, 32'd1);
        send_value(KIND_UDEC, 32'd9);
        send_value(KIND_UDEC, 32'd10);
        send_value(KIND_UDEC, 32'd999_999_999);
        send_value(KIND_UDEC, 32'd1_000_000_000);
        send_value(KIND_UDEC, 32'hFFFF_FFFF);
        send_value(KIND_SDEC, 32'd0);
        send_value(KIND_SDEC, 32'd1);
        send_value(KIND_SDEC, 32'hFFFF_FFFF);
        send_value(KIND_SDEC, 32'hFFFF_FFF6);
        send_value(KIND_SDEC, 32'h7FFF_FFFF);
        send_value(KIND_SDEC, 32'h8000_0000);
        send_value(KIND_SDEC, 32'h8000_0001);
        send_value(KIND_HEX, 32'h0000_0000);
        send_value(KIND_HEX, 32'hFFFF_FFFF);
        send_value(KIND_HEX, 32'h0123_ABCD);
        send_value(KIND_HEX, 32'hFEDC_5432);
        send_value(KIND_HEX_ALIAS, 32'h89AB_CDEF);
        send_value(KIND_HEX_ALIAS, 32'h0000_0000);
    endtask

    task automatic test_random_with_idling();
        idling_on = 1'b1;
        repeat (200) send_value(random_kind(), random_value());
    endtask

    task automatic test_random_back_to_back();
        idling_on = 1'b0;
        repeat (60) send_value(random_kind(), random_value());
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (idling_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        char_beat_t wanted;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected beat: character %h last %b", m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                wanted = pending_chars.pop_front();
                if (m_tdata !== wanted.character)
                begin
                    $error("character: expected %h, actual %h", wanted.character, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== wanted.last)
                begin
                    $error("last: expected %b, actual %b", wanted.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_with_idling();
        test_random_back_to_back();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/i2a_pkg.sv
rtl/i2a_front.sv
rtl/i2a_queue.sv
rtl/i2a_back.sv
rtl/integer_to_ascii_formatter_core.sv
rtl/i2a_checker.sv
tb/tb_integer_to_ascii_formatter_core.sv
